// ===== rtl/nnspf_pkg.sv =====
// ----------------------------------------------------------------------------
// nnspf_pkg
// shared widths, limits and register map of the scaled pixel fetch block
// ----------------------------------------------------------------------------
package nnspf_pkg;

  // limits of the pixel store and of the screen
  localparam int unsigned MaxSrcW   = 256;
  localparam int unsigned MaxSrcH   = 256;
  localparam int unsigned MaxScrDim = 4096;

  // field widths
  localparam int unsigned CoordW  = 12;
  localparam int unsigned ScrW    = 13;
  localparam int unsigned SrcW    = 9;
  localparam int unsigned PixelW  = 32;

  // store addressing: row * MaxSrcW + column
  localparam int unsigned ColW    = $clog2(MaxSrcW);
  localparam int unsigned RowW    = $clog2(MaxSrcH);
  localparam int unsigned AddrW   = ColW + RowW;
  localparam int unsigned Depth   = MaxSrcW * MaxSrcH;

  // divider: dividend = coord * src, quotient is always below src
  localparam int unsigned DivdW   = CoordW + SrcW;
  localparam int unsigned QuotW   = SrcW;
  localparam int unsigned RemW    = ScrW + 1;
  localparam int unsigned CntW    = $clog2(QuotW + 1);

  // configuration port
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;

  typedef enum logic [2:0] {
    RegScreenWidth   = 3'd0,
    RegScreenHeight  = 3'd1,
    RegSourceWidth   = 3'd2,
    RegSourceHeight  = 3'd3,
    RegImageReady    = 3'd4,
    RegBackground    = 3'd5
  } reg_idx_e;

endpackage

// ===== rtl/nnspf_div.sv =====
// ----------------------------------------------------------------------------
// nnspf_div
// restoring divider, one quotient bit a cycle, quotient known to fit QuotW
// ----------------------------------------------------------------------------
module nnspf_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [nnspf_pkg::DivdW-1:0]       dividend_i,
  input  logic [nnspf_pkg::ScrW-1:0]        divisor_i,
  output logic                              busy_o,
  output logic [nnspf_pkg::QuotW-1:0]       quotient_o
);

  logic                             busy_q;
  logic [nnspf_pkg::CntW-1:0]       cnt_q;
  logic [nnspf_pkg::RemW-1:0]       rem_q;
  logic [nnspf_pkg::QuotW-1:0]      quo_q;
  logic [nnspf_pkg::ScrW-1:0]       div_q;
  logic [nnspf_pkg::RemW-1:0]       trial;
  logic [nnspf_pkg::RemW-1:0]       diff;
  logic                             fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_q[nnspf_pkg::RemW-2:0], quo_q[nnspf_pkg::QuotW-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= nnspf_pkg::CntW'(nnspf_pkg::QuotW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == nnspf_pkg::CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // upper dividend bits are below the divisor, so they seed the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= nnspf_pkg::RemW'(dividend_i[nnspf_pkg::DivdW-1:nnspf_pkg::QuotW]);
      quo_q <= dividend_i[nnspf_pkg::QuotW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff : trial;
      quo_q <= {quo_q[nnspf_pkg::QuotW-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/nearest_neighbor_scaled_pixel_fetch_top.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_scaled_pixel_fetch_top
// pixel store with nearest-neighbour scaled screen-pixel queries
// ----------------------------------------------------------------------------
// a store request leaves busy low and the pixel is written at the accepting
// edge; a background query strobes pixel_valid_o in the cycle after it.
// a scaled query holds busy high through the multiply, the 9-step divider
// pair, the store read and the output register, then strobes pixel_valid_o;
// no new request is taken until it is through, and nothing stalls it.
// reset clears the control state but not the store, read or divider data.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaled_pixel_fetch_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode_i,
  input  logic [nnspf_pkg::CoordW-1:0]       x_coord_i,
  input  logic [nnspf_pkg::CoordW-1:0]       y_coord_i,
  input  logic [nnspf_pkg::PixelW-1:0]       pixel_in_i,
  // result channel
  output logic                               pixel_valid_o,
  output logic [nnspf_pkg::PixelW-1:0]       pixel_out_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nnspf_pkg::PaddrW-1:0]       paddr,
  input  logic [nnspf_pkg::PdataW-1:0]       pwdata,
  output logic [nnspf_pkg::PdataW-1:0]       prdata,
  output logic                               pready
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StRead,
    StOut
  } state_e;

  // configuration registers
  logic [nnspf_pkg::ScrW-1:0]    scr_w_q, scr_h_q;
  logic [nnspf_pkg::SrcW-1:0]    src_w_q, src_h_q;
  logic                          ready_q;
  logic [nnspf_pkg::PixelW-1:0]  bg_q;

  logic                          cfg_wr;
  logic [2:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= '0;
      scr_h_q <= '0;
      src_w_q <= '0;
      src_h_q <= '0;
      ready_q <= 1'b0;
      bg_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        nnspf_pkg::RegScreenWidth:  scr_w_q <= pwdata[nnspf_pkg::ScrW-1:0];
        nnspf_pkg::RegScreenHeight: scr_h_q <= pwdata[nnspf_pkg::ScrW-1:0];
        nnspf_pkg::RegSourceWidth:  src_w_q <= pwdata[nnspf_pkg::SrcW-1:0];
        nnspf_pkg::RegSourceHeight: src_h_q <= pwdata[nnspf_pkg::SrcW-1:0];
        nnspf_pkg::RegImageReady:   ready_q <= pwdata[0];
        nnspf_pkg::RegBackground:   bg_q    <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      nnspf_pkg::RegScreenWidth:  prdata = nnspf_pkg::PdataW'(scr_w_q);
      nnspf_pkg::RegScreenHeight: prdata = nnspf_pkg::PdataW'(scr_h_q);
      nnspf_pkg::RegSourceWidth:  prdata = nnspf_pkg::PdataW'(src_w_q);
      nnspf_pkg::RegSourceHeight: prdata = nnspf_pkg::PdataW'(src_h_q);
      nnspf_pkg::RegImageReady:   prdata = nnspf_pkg::PdataW'(ready_q);
      nnspf_pkg::RegBackground:   prdata = bg_q;
      default:                    prdata = '0;
    endcase
  end

  // effective sizes: source sizes saturate at the store limits, screen
  // sizes at the largest screen
  logic [nnspf_pkg::SrcW-1:0] src_w, src_h;
  logic [nnspf_pkg::ScrW-1:0] scr_w, scr_h;

  assign src_w = (src_w_q > nnspf_pkg::SrcW'(nnspf_pkg::MaxSrcW)) ?
                 nnspf_pkg::SrcW'(nnspf_pkg::MaxSrcW) : src_w_q;
  assign src_h = (src_h_q > nnspf_pkg::SrcW'(nnspf_pkg::MaxSrcH)) ?
                 nnspf_pkg::SrcW'(nnspf_pkg::MaxSrcH) : src_h_q;
  assign scr_w = (scr_w_q > nnspf_pkg::ScrW'(nnspf_pkg::MaxScrDim)) ?
                 nnspf_pkg::ScrW'(nnspf_pkg::MaxScrDim) : scr_w_q;
  assign scr_h = (scr_h_q > nnspf_pkg::ScrW'(nnspf_pkg::MaxScrDim)) ?
                 nnspf_pkg::ScrW'(nnspf_pkg::MaxScrDim) : scr_h_q;

  // request decode
  state_e state_q;
  logic   accept;
  logic   store_hit;
  logic   no_image;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // a store outside the current source size is dropped
  assign store_hit = (nnspf_pkg::ScrW'(x_coord_i) < nnspf_pkg::ScrW'(src_w)) &&
                     (nnspf_pkg::ScrW'(y_coord_i) < nnspf_pkg::ScrW'(src_h));

  // any zero size or an image not yet loaded gives the background colour
  assign no_image = !ready_q || (scr_w == '0) || (scr_h == '0) ||
                    (src_w == '0) || (src_h == '0);

  // clamp query coordinates onto the screen
  logic [nnspf_pkg::CoordW-1:0] clamp_x, clamp_y;

  assign clamp_x = (nnspf_pkg::ScrW'(x_coord_i) >= scr_w) ?
                   nnspf_pkg::CoordW'(scr_w - 1'b1) : x_coord_i;
  assign clamp_y = (nnspf_pkg::ScrW'(y_coord_i) >= scr_h) ?
                   nnspf_pkg::CoordW'(scr_h - 1'b1) : y_coord_i;

  // coordinate scaling: coord * src, then divide by screen size
  logic [nnspf_pkg::CoordW-1:0] cx_q, cy_q;
  logic [nnspf_pkg::DivdW-1:0]  prod_x, prod_y;
  logic                         div_start;
  logic                         div_x_busy, div_y_busy;
  logic [nnspf_pkg::QuotW-1:0]  quo_x, quo_y;

  assign prod_x    = nnspf_pkg::DivdW'(cx_q) * nnspf_pkg::DivdW'(src_w);
  assign prod_y    = nnspf_pkg::DivdW'(cy_q) * nnspf_pkg::DivdW'(src_h);
  assign div_start = (state_q == StMul);

  nnspf_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_x),
    .divisor_i  (scr_w),
    .busy_o     (div_x_busy),
    .quotient_o (quo_x)
  );

  nnspf_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_y),
    .divisor_i  (scr_h),
    .busy_o     (div_y_busy),
    .quotient_o (quo_y)
  );

  // clamp the source coordinates below the source size
  logic [nnspf_pkg::ColW-1:0] src_x;
  logic [nnspf_pkg::RowW-1:0] src_y;

  assign src_x = (quo_x >= src_w) ? nnspf_pkg::ColW'(src_w - 1'b1) :
                                    nnspf_pkg::ColW'(quo_x);
  assign src_y = (quo_y >= src_h) ? nnspf_pkg::RowW'(src_h - 1'b1) :
                                    nnspf_pkg::RowW'(quo_y);

  // pixel store: one write port for stores, one registered read for queries;
  // requests run one at a time so the two never meet on the same entry
  logic [nnspf_pkg::PixelW-1:0] store_mem [nnspf_pkg::Depth];
  logic [nnspf_pkg::PixelW-1:0] rd_data_q;
  logic [nnspf_pkg::AddrW-1:0]  wr_addr;
  logic [nnspf_pkg::AddrW-1:0]  rd_addr;
  logic                         mem_we;

  assign mem_we  = accept && !mode_i && store_hit;
  assign wr_addr = {y_coord_i[nnspf_pkg::RowW-1:0], x_coord_i[nnspf_pkg::ColW-1:0]};
  assign rd_addr = {src_y, src_x};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[wr_addr] <= pixel_in_i;
    end
    if (state_q == StRead) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  // query sequencer and result register
  logic                         out_valid_q;
  logic [nnspf_pkg::PixelW-1:0] pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      pixel_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && mode_i) begin
            if (no_image) begin
              pixel_q     <= bg_q;
              out_valid_q <= 1'b1;
            end else begin
              cx_q    <= clamp_x;
              cy_q    <= clamp_y;
              state_q <= StMul;
            end
          end
        end
        StMul: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (!div_x_busy && !div_y_busy) begin
            state_q <= StRead;
          end
        end
        StRead: begin
          state_q <= StOut;
        end
        StOut: begin
          pixel_q     <= rd_data_q;
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign pixel_valid_o = out_valid_q;
  assign pixel_out_o   = pixel_q;

endmodule
